### sv/lsfc_pkg.sv
// Package for the lift state feedback controller: widths, register codes,
// the shared multiplier request type and the quarter-wave cosine table.
// No dependencies.
package lsfc_pkg;

  localparam int COS_TABLE_BITS = 10;
  localparam int VOLT_LIMIT     = 12000;

  localparam int QSTEPS = 1 << COS_TABLE_BITS;
  localparam int ADDR_W = COS_TABLE_BITS + 1;
  localparam int PH_W   = COS_TABLE_BITS + 2;
  localparam int DRIVE_LIM = (VOLT_LIMIT > 16383) ? 16383 : VOLT_LIMIT;

  localparam int SPEED_LIMIT = 160;
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

  // Lift angle phase: ((p << PH_W) + DEN/2) / DEN with DEN = 45 * 2^23 is
  // floor(((p + ANG_BIAS) >> ANG_SHIFT) / 45).
  localparam int ANGLE_DIV = 45;
  localparam int ANG_SHIFT = 21 - COS_TABLE_BITS;
  localparam int ANG_BIAS  = 45 << (20 - COS_TABLE_BITS);
  localparam int P_ANG_W   = 44;
  localparam int MW        = 22 + COS_TABLE_BITS;
  localparam int QW        = MW - 5;
  localparam int R_W       = ((MW > 32) ? (MW - 32) : 0) + 8;
  localparam logic [26:0] RECIP_45 = 27'((64'd1 << 32) / 64'd45);

  localparam int MUL_A_W = (MW + 1 > 33) ? (MW + 1) : 33;
  localparam int MUL_B_W = 28;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam int ACC_W = 58;
  localparam int FB_W  = ACC_W - 20;
  localparam int DRV_W = FB_W + 1;
  localparam int FF_W  = 16;
  localparam int COS_W = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_POSITION    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_VELOCITY    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GEAR_RATIO_Q16   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TOLERANCE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MECHANISM_MODE   = 3'd5;

  localparam logic [1:0] MODE_CONSTANT = 2'd0;
  localparam logic [1:0] MODE_COSINE   = 2'd1;

  typedef struct packed {
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef logic [QSTEPS:0][COS_W-1:0] cos_tab_t;

  // Q30 Taylor series of the cosine through x^14, rounded to Q15.
  function automatic cos_tab_t build_cos_tab();
    cos_tab_t tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic signed [63:0] sum;
    for (int i = 0; i <= QSTEPS; i++) begin
      x   = (PI_HALF_Q30 * 64'(i)) >> COS_TABLE_BITS;
      x2  = (x * x) >> 30;
      t   = 64'd1 << 30;
      sum = $signed(t);
      t = ((t * x2) >> 30) / 64'd2;
      sum = sum - $signed(t);
      t = ((t * x2) >> 30) / 64'd12;
      sum = sum + $signed(t);
      t = ((t * x2) >> 30) / 64'd30;
      sum = sum - $signed(t);
      t = ((t * x2) >> 30) / 64'd56;
      sum = sum + $signed(t);
      t = ((t * x2) >> 30) / 64'd90;
      sum = sum - $signed(t);
      t = ((t * x2) >> 30) / 64'd132;
      sum = sum + $signed(t);
      t = ((t * x2) >> 30) / 64'd182;
      sum = sum - $signed(t);
      if (sum < 0) begin
        sum = 64'sd0;
      end
      tab[i] = COS_W'((sum + 64'sd16384) >>> 15);
    end
    return tab;
  endfunction

  localparam cos_tab_t COS_TAB = build_cos_tab();

endpackage

### sv/lsfc_if.sv
// Handshake interfaces of the lift state feedback controller: sample input,
// drive result and configuration write. No dependencies.
interface lsfc_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] motor_position;
  logic signed [14:0] motor_velocity;
  logic signed [23:0] goal_position;

  modport source (output valid, output motor_position, output motor_velocity,
                  output goal_position, input ready);
  modport sink (input valid, input motor_position, input motor_velocity,
                input goal_position, output ready);
endinterface

interface lsfc_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] drive_millivolts;
  logic               settled;
  logic               saturated;

  modport source (output valid, output drive_millivolts, output settled,
                  output saturated, input ready);
  modport sink (input valid, input drive_millivolts, input settled,
                input saturated, output ready);
endinterface

interface lsfc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### sv/lsfc_cos_rom.sv
// Quarter-wave cosine ROM with a registered read port.
// Depends on lsfc_pkg for the table and its widths.
module lsfc_cos_rom
  import lsfc_pkg::*;
(
  input  logic              clk_i,
  input  logic [ADDR_W-1:0] addr_i,
  output logic [COS_W-1:0]  data_o
);

  logic [COS_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    data_q <= COS_TAB[addr_i];
  end

  assign data_o = data_q;

endmodule

### sv/lsfc_mul.sv
// Shared signed multiplier with a registered product.
// Depends on lsfc_pkg for the request type and widths.
module lsfc_mul
  import lsfc_pkg::*;
(
  input  logic                     clk_i,
  input  mul_req_t                 req_i,
  output logic signed [PROD_W-1:0] prod_o
);

  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(req_i.a) * PROD_W'(req_i.b);
  end

  assign prod_o = prod_q;

endmodule

### sv/lift_state_feedback_controller.sv
// Top level of the lift state feedback controller with gravity feedforward.
// Depends on lsfc_pkg, lsfc_if, lsfc_mul and lsfc_cos_rom.
//
//   Channel   Direction  Handshake     Contents
//   in_req    sink       valid/ready   motor_position, motor_velocity, goal_position
//   out_req   source     valid/ready   drive_millivolts, settled, saturated
//   cfg_req   sink       valid/ready   index, data (always ready)
//
// A feedback tick runs from acceptance through S_ROUND to S_DONE, and a settled
// or holding tick goes from S_FF straight to S_DONE; one shared multiplier runs
// every product in turn, and at most one correction step of the divide by 45
// repeats S_FIX. The block accepts a new request in its idle state, even while
// the previous result waits in the output register; a result that cannot be
// loaded holds the block in its last state. Reset sets the state, configuration,
// holding state and output valid flag at once, but not the datapath registers.
module lift_state_feedback_controller
  import lsfc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  lsfc_in_if.sink    in_req,
  lsfc_out_if.source out_req,
  lsfc_cfg_if.sink   cfg_req
);

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_ANG    = 16'h0002,
    S_BIAS   = 16'h0004,
    S_RECIP  = 16'h0008,
    S_QUOT   = 16'h0010,
    S_BACK   = 16'h0020,
    S_REM    = 16'h0040,
    S_FIX    = 16'h0080,
    S_COS    = 16'h0100,
    S_FFMUL  = 16'h0200,
    S_FF     = 16'h0400,
    S_ERRMUL = 16'h0800,
    S_VELMUL = 16'h1000,
    S_SUM    = 16'h2000,
    S_ROUND  = 16'h4000,
    S_DONE   = 16'h8000
  } lsfc_state_e;

  localparam logic signed [DRV_W-1:0] LIM_POS = DRV_W'(DRIVE_LIM);
  localparam logic signed [DRV_W-1:0] LIM_NEG = -LIM_POS;

  lsfc_state_e state_q, state_d;

  logic signed [31:0] gain_position_q;
  logic signed [31:0] gain_velocity_q;
  logic signed [14:0] gravity_gain_q;
  logic [19:0]        gear_ratio_q;
  logic [22:0]        tolerance_q;
  logic [1:0]         mode_q;
  logic               holding_q;
  logic [23:0]        held_target_q;
  logic               out_valid_q;

  logic [23:0]              mag_q;
  logic [23:0]              target_q;
  logic signed [24:0]       err_q;
  logic signed [17:0]       v6_q;
  logic [MW-1:0]            m_q;
  logic [QW-1:0]            q_q;
  logic [R_W-1:0]           r_q;
  logic signed [COS_W:0]    cos_q;
  logic signed [FF_W-1:0]   ff_q;
  logic                     ff_only_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [FB_W-1:0]   fb_q;
  logic signed [14:0]       drive_q;
  logic                     settled_q;
  logic                     saturated_q;

  mul_req_t                 mul_req;
  logic signed [PROD_W-1:0] prod;
  logic [ADDR_W-1:0]        rom_addr;
  logic [COS_W-1:0]         rom_data;

  logic                     in_fire;
  logic                     out_load;
  logic signed [17:0]       vel_ext;
  logic [24:0]              abs_err;
  logic [17:0]              abs_v6;
  logic                     settle_now;
  logic                     hold_match;
  logic [1:0]               quadrant;
  logic                     cos_neg;
  logic signed [COS_W:0]    cos_raw;
  logic signed [PROD_W-1:0] ff_sum;
  logic signed [ACC_W-1:0]  round_diff;
  logic signed [DRV_W-1:0]  drive_full;

  lsfc_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  lsfc_cos_rom u_cos_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  assign in_req.ready     = (state_q == S_IDLE);
  assign in_fire          = in_req.valid & in_req.ready;
  assign cfg_req.ready    = 1'b1;
  assign out_req.valid    = out_valid_q;
  assign out_req.drive_millivolts = drive_q;
  assign out_req.settled   = settled_q;
  assign out_req.saturated = saturated_q;
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_req.ready);

  assign vel_ext    = 18'(in_req.motor_velocity);
  assign abs_err    = err_q[24] ? 25'(-err_q) : 25'(err_q);
  assign abs_v6     = v6_q[17] ? 18'(-v6_q) : 18'(v6_q);
  assign settle_now = ({2'b00, tolerance_q} > abs_err) && (abs_v6 < 18'(SPEED_LIMIT));
  assign hold_match = holding_q && (target_q == held_target_q);

  assign quadrant = q_q[PH_W-1:COS_TABLE_BITS];
  assign cos_neg  = quadrant[0] ^ quadrant[1];
  assign rom_addr = quadrant[0] ? ADDR_W'(QSTEPS) - {1'b0, q_q[COS_TABLE_BITS-1:0]}
                                : {1'b0, q_q[COS_TABLE_BITS-1:0]};
  assign cos_raw  = $signed({1'b0, rom_data});

  assign ff_sum     = prod + PROD_W'(16384);
  assign round_diff = ACC_W'(524288) - acc_q;
  assign drive_full = ff_only_q ? DRV_W'(ff_q) : DRV_W'(fb_q) + DRV_W'(ff_q);

  always_comb begin
    mul_req = '0;
    case (state_q)
      S_ANG: begin
        mul_req.a = MUL_A_W'({1'b0, mag_q});
        mul_req.b = MUL_B_W'({1'b0, gear_ratio_q});
      end
      S_RECIP: begin
        mul_req.a = MUL_A_W'({1'b0, m_q});
        mul_req.b = MUL_B_W'({1'b0, RECIP_45});
      end
      S_BACK: begin
        mul_req.a = MUL_A_W'({1'b0, q_q});
        mul_req.b = MUL_B_W'(ANGLE_DIV);
      end
      S_FFMUL: begin
        mul_req.a = MUL_A_W'(cos_q);
        mul_req.b = MUL_B_W'(gravity_gain_q);
      end
      S_ERRMUL: begin
        mul_req.a = MUL_A_W'(gain_position_q);
        mul_req.b = MUL_B_W'(err_q);
      end
      S_VELMUL: begin
        mul_req.a = MUL_A_W'(gain_velocity_q);
        mul_req.b = MUL_B_W'(v6_q);
      end
      default: begin
        mul_req = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_fire) state_d = S_ANG;
      S_ANG:    state_d = S_BIAS;
      S_BIAS:   state_d = S_RECIP;
      S_RECIP:  state_d = S_QUOT;
      S_QUOT:   state_d = S_BACK;
      S_BACK:   state_d = S_REM;
      S_REM:    state_d = S_FIX;
      S_FIX:    if (r_q < R_W'(ANGLE_DIV)) state_d = S_COS;
      S_COS:    state_d = S_FFMUL;
      S_FFMUL:  state_d = S_FF;
      S_FF:     state_d = ff_only_q ? S_DONE : S_ERRMUL;
      S_ERRMUL: state_d = S_VELMUL;
      S_VELMUL: state_d = S_SUM;
      S_SUM:    state_d = S_ROUND;
      S_ROUND:  state_d = S_DONE;
      S_DONE:   if (out_load) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      gain_position_q <= '0;
      gain_velocity_q <= '0;
      gravity_gain_q  <= '0;
      gear_ratio_q    <= 20'd65536;
      tolerance_q     <= 23'd16;
      mode_q          <= MODE_CONSTANT;
      holding_q       <= 1'b0;
      held_target_q   <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_req.valid && cfg_req.ready) begin
        unique case (cfg_req.index)
          REG_GAIN_POSITION:    gain_position_q <= $signed(cfg_req.data);
          REG_GAIN_VELOCITY:    gain_velocity_q <= $signed(cfg_req.data);
          REG_GRAVITY_GAIN:     gravity_gain_q  <= $signed(cfg_req.data[14:0]);
          REG_GEAR_RATIO_Q16:   gear_ratio_q    <= cfg_req.data[19:0];
          REG_SETTLE_TOLERANCE: tolerance_q     <= cfg_req.data[22:0];
          REG_MECHANISM_MODE:   mode_q          <= cfg_req.data[1:0];
          default: begin
          end
        endcase
      end
      if (state_q == S_ANG && !hold_match) begin
        holding_q <= settle_now;
        if (settle_now) begin
          held_target_q <= target_q;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_req.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          mag_q    <= in_req.motor_position[23] ? 24'(-in_req.motor_position)
                                                : 24'(in_req.motor_position);
          target_q <= in_req.goal_position;
          err_q    <= 25'(in_req.motor_position) - 25'(in_req.goal_position);
          v6_q     <= (vel_ext <<< 2) + (vel_ext <<< 1);
        end
      end
      S_ANG: begin
        ff_only_q <= hold_match || settle_now;
      end
      S_BIAS: begin
        m_q <= MW'(((P_ANG_W + 1)'(prod[P_ANG_W-1:0]) + (P_ANG_W + 1)'(ANG_BIAS))
                   >> ANG_SHIFT);
      end
      S_QUOT: begin
        q_q <= prod[32 +: QW];
      end
      S_REM: begin
        r_q <= R_W'(m_q - prod[MW-1:0]);
      end
      S_FIX: begin
        if (r_q >= R_W'(ANGLE_DIV)) begin
          r_q <= r_q - R_W'(ANGLE_DIV);
          q_q <= q_q + QW'(1);
        end
      end
      S_COS: begin
        cos_q <= cos_neg ? -cos_raw : cos_raw;
      end
      S_FF: begin
        case (mode_q)
          MODE_CONSTANT: ff_q <= FF_W'(gravity_gain_q);
          MODE_COSINE:   ff_q <= FF_W'(ff_sum >>> 15);
          default:       ff_q <= '0;
        endcase
      end
      S_VELMUL: begin
        acc_q <= ACC_W'(prod);
      end
      S_SUM: begin
        acc_q <= acc_q + ACC_W'(prod);
      end
      S_ROUND: begin
        fb_q <= FB_W'(round_diff >>> 20);
      end
      S_DONE: begin
        if (out_load) begin
          settled_q <= ff_only_q;
          if (drive_full > LIM_POS) begin
            drive_q     <= 15'(LIM_POS);
            saturated_q <= 1'b1;
          end else if (drive_full < LIM_NEG) begin
            drive_q     <= 15'(LIM_NEG);
            saturated_q <= 1'b1;
          end else begin
            drive_q     <= 15'(drive_full);
            saturated_q <= 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule
